### sv/gb3_pkg.sv
`default_nettype none

package gb3_pkg;

   // Register indexes on the csr port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_CENTER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_EDGE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_CORNER = 3'd4;

   // Register reset values
   localparam logic [11:0] RESET_IMAGE_WIDTH   = 12'd640;
   localparam logic [11:0] RESET_IMAGE_HEIGHT  = 12'd480;
   localparam logic [15:0] RESET_WEIGHT_CENTER = 16'd8088;
   localparam logic [15:0] RESET_WEIGHT_EDGE   = 16'd7468;
   localparam logic [15:0] RESET_WEIGHT_CORNER = 16'd6894;

   // Frame geometry limits
   localparam int          MIN_DIM    = 3;
   localparam logic [11:0] MAX_HEIGHT = 12'd2048;
   localparam int          ROW_W      = 11;
   localparam int          POS_OUT_W  = 11;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]           blurred;
      logic [POS_OUT_W-1:0] out_row;
      logic [POS_OUT_W-1:0] out_col;
      logic                 frame_last;
   } rsp_type;

endpackage

`default_nettype wire

### sv/gb3_ram.sv
`default_nettype none

module gb3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/gaussian_blur_3x3.sv
`default_nettype none

// 3x3 Gaussian blur on a raster stream of 8-bit pixels, one pixel per clock.
// Pixels arrive row by row; frame_start forces the pixel to row 0, column 0,
// and position also wraps on its own after the last pixel of a frame. Each
// interior pixel (not in the first/last row or column) yields one result,
// sum of w*pixel over the window in Q0.16, floored and saturated at 255,
// tagged with the window center's row/column and a flag on the frame's last
// result. A result goes through the read register, then the output register,
// after the request that completes the window (the pixel below-right of the
// center) is accepted. Sustained rate is one request per cycle; the path is a
// line-store read register, then tap sums, weight products and the
// add/saturate into the output register. The input stalls only while a
// result waits in the output register and the read register is occupied.
// Two line stores of MAX_WIDTH bytes hold the previous lines; they need no
// clearing. Registers: 0 image_width, 1 image_height (both clamped to
// 3..MAX_WIDTH / 3..2048), 2..4 center, edge and corner weights. Write
// registers only while the block is idle; csr_ready is always high.
module gaussian_blur_3x3 #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire gb3_pkg::req_type                     req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output gb3_pkg::rsp_type                          rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [gb3_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [gb3_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = ((EW_W > 12) ? EW_W : 12) + 1;

   // Configuration registers
   logic [11:0] width_ff, height_ff;
   logic [15:0] weight_center_ff, weight_edge_ff, weight_corner_ff;

   // Position
   logic [COL_W-1:0]          col_ff, col_in;
   logic [gb3_pkg::ROW_W-1:0] row_ff, row_in;

   logic [CMP_W-1:0] ew, c0, c1, col_inc;
   logic [11:0]      eh, r0, r1, row_inc;
   logic [CMP_W-1:0] cur_col;
   logic [11:0]      cur_row;
   logic [CMP_W-1:0] col_m1;
   logic [11:0]      row_m1;
   logic             cur_produce, cur_last;

   // Stage enables
   logic en1, en_out, accept;

   // S1: line-store read
   logic                             s1_valid_ff, s1_produce_ff, s1_last_ff;
   logic [COL_W-1:0]                 s1_addr_ff;
   logic [7:0]                       s1_pixel_ff;
   logic [gb3_pkg::POS_OUT_W-1:0]    s1_row_ff, s1_col_ff;
   logic                             s1_byp_ff;
   logic [7:0]                       s1_byp_top_ff, s1_byp_mid_ff;
   logic [7:0]                       ram_top, ram_mid, s1_top, s1_mid;
   logic [7:0]                       win_ff [6];
   logic [9:0]                       corners, edges;

   // Weighted sum
   logic [23:0]                      prod_center;
   logic [25:0]                      prod_edge, prod_corner;
   logic [27:0]                      sum;
   logic [11:0]                      sum_int;

   // Output register
   logic                             rsp_valid_ff;
   gb3_pkg::rsp_type                 rsp_ff;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff         <= gb3_pkg::RESET_IMAGE_WIDTH;
         height_ff        <= gb3_pkg::RESET_IMAGE_HEIGHT;
         weight_center_ff <= gb3_pkg::RESET_WEIGHT_CENTER;
         weight_edge_ff   <= gb3_pkg::RESET_WEIGHT_EDGE;
         weight_corner_ff <= gb3_pkg::RESET_WEIGHT_CORNER;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gb3_pkg::CSR_IMAGE_WIDTH:   width_ff         <= csr_data[11:0];
            gb3_pkg::CSR_IMAGE_HEIGHT:  height_ff        <= csr_data[11:0];
            gb3_pkg::CSR_WEIGHT_CENTER: weight_center_ff <= csr_data;
            gb3_pkg::CSR_WEIGHT_EDGE:   weight_edge_ff   <= csr_data;
            gb3_pkg::CSR_WEIGHT_CORNER: weight_corner_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective frame size
   always_comb begin
      if (CMP_W'(width_ff) < CMP_W'(gb3_pkg::MIN_DIM)) begin
         ew = CMP_W'(gb3_pkg::MIN_DIM);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         ew = CMP_W'(MAX_WIDTH);
      end else begin
         ew = CMP_W'(width_ff);
      end
      if (height_ff < 12'(gb3_pkg::MIN_DIM)) begin
         eh = 12'(gb3_pkg::MIN_DIM);
      end else if (height_ff > gb3_pkg::MAX_HEIGHT) begin
         eh = gb3_pkg::MAX_HEIGHT;
      end else begin
         eh = height_ff;
      end
   end

   // Position of the incoming pixel and of the one after it
   always_comb begin
      c0 = req_payload.frame_start ? '0 : CMP_W'(col_ff);
      r0 = req_payload.frame_start ? '0 : 12'(row_ff);
      if (c0 >= ew) begin
         c1 = '0;
         r1 = r0 + 12'd1;
      end else begin
         c1 = c0;
         r1 = r0;
      end
      cur_row = (r1 >= eh) ? '0 : r1;
      cur_col = c1;

      col_inc = cur_col + CMP_W'(1);
      row_inc = cur_row + 12'd1;
      if (col_inc >= ew) begin
         col_in = '0;
         row_in = (row_inc >= eh) ? '0 : row_inc[gb3_pkg::ROW_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = cur_row[gb3_pkg::ROW_W-1:0];
      end

      col_m1      = cur_col - CMP_W'(1);
      row_m1      = cur_row - 12'd1;
      cur_produce = (cur_row >= 12'd2) && (cur_col >= CMP_W'(2));
      cur_last    = (cur_row == eh - 12'd1) && (cur_col == ew - CMP_W'(1));
   end

   // Stage enables: a stage loads when it is empty or its contents move on
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en1       = !s1_valid_ff || en_out;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores: upper gets the old middle line, middle gets the new pixel
   gb3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_upper (
      .clock   (clock),
      .wr_en   (en1 && s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_mid),
      .rd_en   (en1),
      .rd_addr (cur_col[COL_W-1:0]),
      .rd_data (ram_top)
   );

   gb3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_middle (
      .clock   (clock),
      .wr_en   (en1 && s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (en1),
      .rd_addr (cur_col[COL_W-1:0]),
      .rd_data (ram_mid)
   );

   // S1 register; bypass when the read hits the column written this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_produce_ff <= cur_produce;
         s1_last_ff    <= cur_last;
         s1_addr_ff    <= cur_col[COL_W-1:0];
         s1_pixel_ff   <= req_payload.pixel;
         s1_row_ff     <= row_m1[gb3_pkg::POS_OUT_W-1:0];
         s1_col_ff     <= col_m1[gb3_pkg::POS_OUT_W-1:0];
         s1_byp_ff     <= accept && s1_valid_ff && (cur_col[COL_W-1:0] == s1_addr_ff);
         s1_byp_top_ff <= s1_mid;
         s1_byp_mid_ff <= s1_pixel_ff;
      end
   end

   assign s1_top = s1_byp_ff ? s1_byp_top_ff : ram_top;
   assign s1_mid = s1_byp_ff ? s1_byp_mid_ff : ram_mid;

   // Window: [0..2] two columns back, [3..5] one column back (top, mid, bottom)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (en1 && s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= s1_top;
         win_ff[4] <= s1_mid;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   assign corners = 10'(win_ff[0]) + 10'(win_ff[2]) + 10'(s1_top) + 10'(s1_pixel_ff);
   assign edges   = 10'(win_ff[1]) + 10'(win_ff[3]) + 10'(win_ff[5]) + 10'(s1_mid);

   // Weight products, exact sum, floor
   assign prod_center = 24'(weight_center_ff) * 24'(win_ff[4]);
   assign prod_edge   = 26'(weight_edge_ff) * 26'(edges);
   assign prod_corner = 26'(weight_corner_ff) * 26'(corners);
   assign sum         = 28'(prod_center) + 28'(prod_edge) + 28'(prod_corner);
   assign sum_int     = sum[27:16];

   // Output register, saturated at 255
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= s1_valid_ff && s1_produce_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ff.blurred    <= (sum_int[11:8] != 4'd0) ? 8'hFF : sum_int[7:0];
         rsp_ff.out_row    <= s1_row_ff;
         rsp_ff.out_col    <= s1_col_ff;
         rsp_ff.frame_last <= s1_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   function automatic logic [gb3_pkg::POS_OUT_W-1:0] row_m1_last_chk(logic [11:0] h);
      logic [11:0] t;
      t = h - 12'd2;
      return t[gb3_pkg::POS_OUT_W-1:0];
   endfunction

   // A bypass is only armed for a request that is now sitting in S1
   a_bypass_occupied: assert property (@(posedge clock) disable iff (reset)
      s1_byp_ff |-> s1_valid_ff)
      else $error("line-store bypass armed with empty read stage");

   // A finished sum never gets lost on its way to the output register
   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      (en_out && s1_valid_ff && s1_produce_ff) |=> rsp_valid_ff)
      else $error("result dropped between read stage and output");

   // The last result of a frame is centered on the second-to-last row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_last)
         |-> (rsp_ff.out_row == row_m1_last_chk(eh)))
      else $error("frame_last flagged on wrong row");
`endif

endmodule

`default_nettype wire
